### hw/rtl/rwps_pkg.sv
// ----------------------------------------------------------------------------
// rwps_pkg
// Shared types and constants for the signal strength window peak statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package rwps_pkg;

  localparam int CMD_W    = 2;
  localparam int CODE_W   = 14;
  localparam int DBM_W    = 13;
  localparam int WLEN_W   = 10;
  localparam int CNT_W    = 7;
  localparam int SUM_W    = 15;
  localparam int BYTE_W   = 8;

  // input commands
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;

  // result kinds
  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [CNT_W-1:0]         HISTORY_LIMIT       = 7'd100;
  localparam logic [CODE_W:0]          CODE_OFFSET         = 15'd16384;
  localparam logic signed [DBM_W-1:0]  WINDOW_START        = -13'sd200;
  localparam logic [WLEN_W-1:0]        WINDOW_RESET_LENGTH = 10'd500;

  // one quotient bit per step
  localparam int DIV_STEPS = SUM_W;

  // controller -> datapath
  typedef struct packed {
    logic item_load;
    logic start;
    logic sample_upd;
    logic peak_emit;
    logic div_start;
    logic summary_emit;
  } rwps_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             measuring;
    logic             window_done;
    logic             count_zero;
    logic             out_free;
    logic             div_busy;
  } rwps_sts_t;

endpackage

`default_nettype wire

### hw/rtl/rwps_div.sv
// ----------------------------------------------------------------------------
// rwps_div
// Restoring divider, history sum by history count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rwps_div import rwps_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic [SUM_W-1:0]      quotient_o
);

  localparam int StepW = $clog2(DIV_STEPS);

  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] work_q, work_d;

  logic [CNT_W:0] trial;
  logic           fits;

  // work_q shifts dividend bits out at the top and quotient bits in at the bottom
  assign trial = {rem_q, work_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    work_d = work_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(DIV_STEPS - 1);
      rem_d  = '0;
      work_d = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? CNT_W'(trial - {1'b0, divisor_i}) : trial[CNT_W-1:0];
      work_d = {work_q[SUM_W-2:0], fits};
      if (step_q == '0) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    work_q <= work_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = work_q;

endmodule

`default_nettype wire

### hw/rtl/rwps_ctrl.sv
// ----------------------------------------------------------------------------
// rwps_ctrl
// Sequencer: takes one word, runs it through the datapath, waits on the
// divider and on the output register where needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rwps_ctrl import rwps_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire rwps_sts_t sts_i,
  output rwps_ctl_t      ctl_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.item_load = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.cmd)
          CMD_START: begin
            ctl_o.start = 1'b1;
            state_d     = ST_IDLE;
          end
          CMD_STOP: begin
            if (sts_i.count_zero) begin
              state_d = ST_REPORT;
            end else begin
              ctl_o.div_start = 1'b1;
              state_d         = ST_DIV;
            end
          end
          CMD_SAMPLE: begin
            if (!sts_i.measuring) begin
              state_d = ST_IDLE;
            end else if (!sts_i.window_done) begin
              ctl_o.sample_upd = 1'b1;
              state_d          = ST_IDLE;
            end else if (sts_i.out_free) begin
              ctl_o.peak_emit = 1'b1;
              state_d         = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (sts_i.out_free) begin
          ctl_o.summary_emit = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rwps_dp.sv
// ----------------------------------------------------------------------------
// rwps_dp
// Datapath: word register, window peak tracking, history statistics,
// mean divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rwps_dp import rwps_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rwps_ctl_t         ctl_i,
  output rwps_sts_t              sts_o,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [CODE_W-1:0] raw_code_i,
  input  wire logic              cfg_valid_i,
  input  wire logic [WLEN_W-1:0] cfg_wdata_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output logic                   kind_o,
  output logic [BYTE_W-1:0]      peak_magnitude_o,
  output logic [BYTE_W-1:0]      mean_value_o,
  output logic [BYTE_W-1:0]      largest_value_o,
  output logic [BYTE_W-1:0]      smallest_value_o,
  output logic                   empty_history_o
);

  // word register
  logic [CMD_W-1:0]  cmd_q;
  logic [CODE_W-1:0] code_q;

  // measurement state
  logic                    measuring_q, measuring_d;
  logic [WLEN_W-1:0]       wlen_q;
  logic [WLEN_W-1:0]       wcnt_q, wcnt_d;
  logic signed [DBM_W-1:0] wmax_q, wmax_d;
  logic [CNT_W-1:0]        hcnt_q, hcnt_d;
  logic [SUM_W-1:0]        hsum_q, hsum_d;
  logic [BYTE_W-1:0]       hmin_q, hmin_d;
  logic [BYTE_W-1:0]       hmax_q, hmax_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              kind_q;
  logic [BYTE_W-1:0] peak_q, mean_q, large_q, small_q;
  logic              empty_q;

  logic [CODE_W:0]         diff;
  logic [DBM_W-1:0]        mag_in;
  logic signed [DBM_W-1:0] dbm, base, new_max;
  logic [DBM_W-1:0]        max_abs;
  logic [BYTE_W-1:0]       peak_mag;
  logic [WLEN_W-1:0]       wcnt_inc;
  logic                    window_done;
  logic                    count_zero;
  logic                    out_free;
  logic                    div_busy;
  logic [SUM_W-1:0]        quotient;

  rwps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (hsum_q),
    .divisor_i  (hcnt_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // dBm = -((16384 - code) >> 2), always in -4096..0
  assign diff     = CODE_OFFSET - {1'b0, code_q};
  assign mag_in   = diff[CODE_W:2];
  assign dbm      = signed'(DBM_W'(13'd0 - mag_in));
  assign base     = (wcnt_q == '0) ? WINDOW_START : wmax_q;
  assign new_max  = (dbm > base) ? dbm : base;
  assign max_abs  = new_max[DBM_W-1] ? DBM_W'(13'd0 - new_max) : new_max;
  assign peak_mag = max_abs[BYTE_W-1:0];

  assign wcnt_inc    = wcnt_q + 1'b1;
  assign window_done = (wcnt_inc >= wlen_q);
  assign count_zero  = (hcnt_q == '0);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign sts_o.cmd         = cmd_q;
  assign sts_o.measuring   = measuring_q;
  assign sts_o.window_done = window_done;
  assign sts_o.count_zero  = count_zero;
  assign sts_o.out_free    = out_free;
  assign sts_o.div_busy    = div_busy;

  always_comb begin
    measuring_d = measuring_q;
    wcnt_d      = wcnt_q;
    wmax_d      = wmax_q;
    hcnt_d      = hcnt_q;
    hsum_d      = hsum_q;
    hmin_d      = hmin_q;
    hmax_d      = hmax_q;
    if (ctl_i.start) begin
      measuring_d = 1'b1;
      wcnt_d      = '0;
      wmax_d      = WINDOW_START;
    end
    if (ctl_i.sample_upd) begin
      wcnt_d = wcnt_inc;
      wmax_d = new_max;
    end
    if (ctl_i.peak_emit) begin
      wcnt_d = '0;
      wmax_d = new_max;
      // full history: peak still goes out, just not recorded
      if (hcnt_q < HISTORY_LIMIT) begin
        hsum_d = SUM_W'(hsum_q + {7'd0, peak_mag});
        hcnt_d = hcnt_q + 1'b1;
        if (count_zero || peak_mag < hmin_q) begin
          hmin_d = peak_mag;
        end
        if (count_zero || peak_mag > hmax_q) begin
          hmax_d = peak_mag;
        end
      end
    end
    if (ctl_i.summary_emit) begin
      measuring_d = 1'b0;
      hcnt_d      = '0;
      hsum_d      = '0;
      hmin_d      = '0;
      hmax_d      = '0;
    end
  end

  assign out_valid_d = (ctl_i.peak_emit || ctl_i.summary_emit) ? 1'b1
                                                               : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      measuring_q <= 1'b0;
      wlen_q      <= WINDOW_RESET_LENGTH;
      wcnt_q      <= '0;
      wmax_q      <= WINDOW_START;
      hcnt_q      <= '0;
      hsum_q      <= '0;
      hmin_q      <= '0;
      hmax_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      measuring_q <= measuring_d;
      wcnt_q      <= wcnt_d;
      wmax_q      <= wmax_d;
      hcnt_q      <= hcnt_d;
      hsum_q      <= hsum_d;
      hmin_q      <= hmin_d;
      hmax_q      <= hmax_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        wlen_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.item_load) begin
      cmd_q  <= cmd_i;
      code_q <= raw_code_i;
    end
    if (ctl_i.peak_emit) begin
      kind_q  <= KIND_PEAK;
      peak_q  <= peak_mag;
      mean_q  <= '0;
      large_q <= '0;
      small_q <= '0;
      empty_q <= 1'b0;
    end else if (ctl_i.summary_emit) begin
      kind_q  <= KIND_SUMMARY;
      peak_q  <= '0;
      mean_q  <= count_zero ? '0 : quotient[BYTE_W-1:0];
      large_q <= count_zero ? '0 : hmax_q;
      small_q <= count_zero ? '0 : hmin_q;
      empty_q <= count_zero;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign peak_magnitude_o = peak_q;
  assign mean_value_o     = mean_q;
  assign largest_value_o  = large_q;
  assign smallest_value_o = small_q;
  assign empty_history_o  = empty_q;

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.peak_emit || ctl_i.summary_emit) |-> out_free)
    else $error("result loaded over a word not yet taken");

  a_hist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= HISTORY_LIMIT)
    else $error("history count past limit");

  a_summary_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.summary_emit |=> (hcnt_q == '0 && hsum_q == '0 && !measuring_q))
    else $error("history not cleared after summary");

  a_div_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.div_start |=> div_busy)
    else $error("divider did not start");

  a_stop_only_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(measuring_q) |-> $past(ctl_i.summary_emit))
    else $error("measurement ended without a summary");

endmodule

`default_nettype wire

### hw/rtl/rssi_window_peak_statistics.sv
// ----------------------------------------------------------------------------
// rssi_window_peak_statistics
// Signal strength window peak tracker with stop-time history summary.
// ----------------------------------------------------------------------------
// One input word is handled at a time. A sample or start word is accepted,
// then executed. A stop word with an empty history is accepted, executed and
// reported; otherwise the mean comes from a serial restoring divider that
// makes one of 15 quotient bits per cycle, then the sequencer sees the divider
// done and reports. A word that must produce a
// result holds the block until the output register is free, so a stalled
// output adds its stall cycles to that word. Results sit in an output
// register, so the next word is accepted while a result still waits.
// The window length register may be written at any time the block is idle.
`default_nettype none

module rssi_window_peak_statistics import rwps_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [CODE_W-1:0] raw_code_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [WLEN_W-1:0] cfg_wdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   kind_o,
  output logic [BYTE_W-1:0]      peak_magnitude_o,
  output logic [BYTE_W-1:0]      mean_value_o,
  output logic [BYTE_W-1:0]      largest_value_o,
  output logic [BYTE_W-1:0]      smallest_value_o,
  output logic                   empty_history_o
);

  rwps_ctl_t ctl;
  rwps_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rwps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  rwps_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .cmd_i            (cmd_i),
    .raw_code_i       (raw_code_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .kind_o           (kind_o),
    .peak_magnitude_o (peak_magnitude_o),
    .mean_value_o     (mean_value_o),
    .largest_value_o  (largest_value_o),
    .smallest_value_o (smallest_value_o),
    .empty_history_o  (empty_history_o)
  );

endmodule

`default_nettype wire

### tb/sv/tb_rssi_window_peak_statistics.sv
// ----------------------------------------------------------------------------
// tb_rssi_window_peak_statistics
// Self-checking bench for the window peak tracker and its history summary.
// Words go in one at a time through the valid/stall input port. An in-bench
// copy of the peak and history state predicts every peak and summary word.
// A monitor process compares each output word with the oldest prediction.
// The window length is rewritten only while no word is in flight. The tests
// cover idle commands, the default length, zero and unit lengths, a lowered
// length, a full history and long random runs of start/sample/stop sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rssi_window_peak_statistics;
  import rwps_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS    = 1050;
  localparam int SETTLE_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] peak_magnitude;
    logic [BYTE_W-1:0] mean_value;
    logic [BYTE_W-1:0] largest_value;
    logic [BYTE_W-1:0] smallest_value;
    logic              empty_history;
  } report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  cmd_i = CMD_SAMPLE;
  logic [CODE_W-1:0] raw_code_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [WLEN_W-1:0] cfg_wdata_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              kind_o;
  logic [BYTE_W-1:0] peak_magnitude_o;
  logic [BYTE_W-1:0] mean_value_o;
  logic [BYTE_W-1:0] largest_value_o;
  logic [BYTE_W-1:0] smallest_value_o;
  logic              empty_history_o;

  rssi_window_peak_statistics u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .raw_code_i       (raw_code_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .peak_magnitude_o (peak_magnitude_o),
    .mean_value_o     (mean_value_o),
    .largest_value_o  (largest_value_o),
    .smallest_value_o (smallest_value_o),
    .empty_history_o  (empty_history_o)
  );

  always #5 clk_i = ~clk_i;

  // bench copy of the block state
  logic                     measuring  = 1'b0;
  logic [WLEN_W-1:0]        win_count  = '0;
  logic signed [DBM_W-1:0]  win_max    = WINDOW_START;
  logic [CNT_W-1:0]         hist_count = '0;
  logic [SUM_W-1:0]         hist_sum   = '0;
  logic [BYTE_W-1:0]        hist_min   = '0;
  logic [BYTE_W-1:0]        hist_max   = '0;
  logic [WLEN_W-1:0]        window_len = WINDOW_RESET_LENGTH;

  report_t     pending_reports[$];
  logic        mismatch_seen = 1'b0;
  int unsigned words_used = 0;
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 83;
  int unsigned quiet_cycles = 0;

  function automatic void predict_word(input logic [CMD_W-1:0] cmd,
                                       input logic [CODE_W-1:0] code);
    report_t                 rep;
    int                      dbm_full;
    logic signed [DBM_W-1:0] dbm;
    int                      mag_full;
    logic [BYTE_W-1:0]       mag;
    logic [SUM_W-1:0]        quotient;
    rep = '0;
    case (cmd)
      CMD_START: begin
        measuring = 1'b1;
        win_count = '0;
        win_max   = WINDOW_START;
      end
      CMD_STOP: begin
        rep.kind  = KIND_SUMMARY;
        measuring = 1'b0;
        if (hist_count == 0) begin
          rep.empty_history = 1'b1;
        end else begin
          quotient           = hist_sum / hist_count;
          rep.mean_value     = quotient[BYTE_W-1:0];
          rep.largest_value  = hist_max;
          rep.smallest_value = hist_min;
        end
        hist_count = '0;
        hist_sum   = '0;
        hist_min   = '0;
        hist_max   = '0;
        pending_reports.push_back(rep);
      end
      CMD_SAMPLE: begin
        if (measuring) begin
          dbm_full = (int'(code) - int'(CODE_OFFSET)) / 4;
          dbm      = dbm_full[DBM_W-1:0];
          if (win_count == 0) win_max = WINDOW_START;
          if (dbm > win_max) win_max = dbm;
          win_count = win_count + 1'b1;
          // counter reaching or passing the length closes the window
          if (win_count >= window_len) begin
            mag_full = (win_max < 0) ? -int'(win_max) : int'(win_max);
            mag      = mag_full[BYTE_W-1:0];
            if (hist_count < HISTORY_LIMIT) begin
              hist_sum = hist_sum + mag;
              if (hist_count == 0) begin
                hist_min = mag;
                hist_max = mag;
              end else begin
                if (mag < hist_min) hist_min = mag;
                if (mag > hist_max) hist_max = mag;
              end
              hist_count = hist_count + 1'b1;
            end
            win_count = '0;
            rep.kind           = KIND_PEAK;
            rep.peak_magnitude = mag;
            pending_reports.push_back(rep);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  // output monitor and receiver stall
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("result word with no prediction pending");
        mismatch_seen = 1'b1;
      end else begin
        want = pending_reports.pop_front();
        compare_field("kind", want.kind, kind_o);
        compare_field("peak_magnitude", want.peak_magnitude, peak_magnitude_o);
        compare_field("mean_value", want.mean_value, mean_value_o);
        compare_field("largest_value", want.largest_value, largest_value_o);
        compare_field("smallest_value", want.smallest_value, smallest_value_o);
        compare_field("empty_history", want.empty_history, empty_history_o);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [CODE_W-1:0] rand_code();
    // mostly near full scale so window maxima land above -200 dBm
    if ($urandom_range(3) == 0) return CODE_W'($urandom_range(16383));
    return CODE_W'($urandom_range(16383, 16383 - $urandom_range(1100)));
  endfunction

  function automatic logic [WLEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 70) return WLEN_W'($urandom_range(1, 6));
    return WLEN_W'($urandom_range(7, 40));
  endfunction

  // valid stays high after acceptance; the next call or a drain lowers it
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    raw_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    words_used++;
    predict_word(cmd, code);
  endtask

  task automatic wait_until_quiet();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    // start words and sample words that close no window leave no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window_length(input logic [WLEN_W-1:0] len);
    wait_until_quiet();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    window_len = len;
  endtask

  task automatic test_idle_commands();
    send_word(CMD_STOP, '0);
    send_word(CMD_SAMPLE, 14'h3FFF);
    send_word(CMD_UNUSED, '0);
    send_word(CMD_STOP, 14'h3FFF);
  endtask

  task automatic test_default_length();
    send_word(CMD_START, '0);
    repeat (int'(WINDOW_RESET_LENGTH) + 3) send_word(CMD_SAMPLE, rand_code());
    send_word(CMD_STOP, '0);
  endtask

  task automatic test_directed_windows();
    set_window_length(10'd1);
    send_word(CMD_START, '0);
    send_word(CMD_SAMPLE, 14'h0000);
    send_word(CMD_SAMPLE, 14'h3FFF);
    send_word(CMD_SAMPLE, 14'h2AAA);
    send_word(CMD_SAMPLE, 14'h1555);
    send_word(CMD_SAMPLE, 14'd16380);
    send_word(CMD_SAMPLE, 14'd15584);
    send_word(CMD_UNUSED, 14'h3FFF);
    send_word(CMD_START, '0);
    set_window_length(10'd3);
    send_word(CMD_SAMPLE, 14'd16000);
    send_word(CMD_SAMPLE, 14'd15900);
    send_word(CMD_SAMPLE, 14'd16100);
    send_word(CMD_STOP, '0);
    send_word(CMD_STOP, '0);
    // length lowered below the running count mid-window
    set_window_length(10'd5);
    send_word(CMD_START, '0);
    repeat (3) send_word(CMD_SAMPLE, rand_code());
    set_window_length(10'd2);
    send_word(CMD_SAMPLE, rand_code());
    // zero length closes every window after one word
    set_window_length(10'd0);
    send_word(CMD_START, '0);
    send_word(CMD_SAMPLE, rand_code());
    send_word(CMD_SAMPLE, rand_code());
    send_word(CMD_STOP, '0);
  endtask

  task automatic test_history_full();
    set_window_length(10'd1);
    send_word(CMD_START, '0);
    repeat (int'(HISTORY_LIMIT) + 4) send_word(CMD_SAMPLE, rand_code());
    send_word(CMD_STOP, '0);
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned done;
    int unsigned n;
    first = words_used;
    set_window_length(pick_length());
    while (words_used - first < RANDOM_WORDS) begin
      done = words_used - first;
      if (done < RANDOM_WORDS / 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 83;
      end else if (done < 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4)) send_word(CMD_W'($urandom_range(3)), rand_code());
      end else begin
        if ($urandom_range(2) == 0) set_window_length(pick_length());
        n = $urandom_range(1, 4 * (int'(window_len) + 1));
        send_word(CMD_START, rand_code());
        repeat (n) begin
          case ($urandom_range(19))
            0: send_word(CMD_UNUSED, rand_code());
            1: send_word(CMD_START, rand_code());
            2: set_window_length(pick_length());
            default: ;
          endcase
          send_word(CMD_SAMPLE, rand_code());
        end
        if ($urandom_range(9) != 0) send_word(CMD_STOP, rand_code());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_commands();
    test_default_length();
    test_directed_windows();
    test_history_full();
    test_random_traffic();
    wait_until_quiet();
    if (mismatch_seen) begin
      $display("Mismatches found");
    end else begin
      $display("No mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hw/rtl/rwps_pkg.sv
hw/rtl/rwps_div.sv
hw/rtl/rwps_ctrl.sv
hw/rtl/rwps_dp.sv
hw/rtl/rssi_window_peak_statistics.sv
tb/sv/tb_rssi_window_peak_statistics.sv
